// ----- rtl/pcpa_pkg.sv -----
// Package for the per-CPU page free list allocator.
// Holds operation, status and state codes, register reset values and the
// command and status structs shared by the controller and the datapath.
package pcpa_pkg;

    // Default sizes of the page store and the processor count.
    localparam int unsigned DEF_NUM_PAGES = 32768;
    localparam int unsigned DEF_NUM_CPUS  = 8;

    // Fixed widths of the payload.
    localparam int unsigned ADDR_W    = 40;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned CPU_W     = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned PAGE_SH   = 12;

    // Configuration register indexes and reset values.
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_TOP  = 1'b1;
    localparam logic [ADDR_W-1:0] BASE_RESET = 40'h0080000000;
    localparam logic [ADDR_W-1:0] TOP_RESET  = 40'h0088000000;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_INIT  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CPU_RD,
        S_GLB_RD,
        S_INIT,
        S_ST_CPU,
        S_ST_WALK,
        S_ST_WR
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CPU_RD,
        OP_GLB_RD,
        OP_POP_CPU,
        OP_POP_GLB,
        OP_FREE,
        OP_INIT_SET,
        OP_INIT_PUSH,
        OP_ST_INIT,
        OP_ST_NEXT,
        OP_ST_LOAD,
        OP_ST_RD,
        OP_ST_PUSH,
        OP_ST_END,
        OP_RESP_OK,
        OP_RESP_OOM,
        OP_RESP_BAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    // Conditions the datapath reports back to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cpu_nonempty;
        logic              glb_nonempty;
        logic              free_ok;
        logic              init_more;
        logic              st_end;
        logic              st_is_me;
        logic              walk_more;
    } t_dp_stat;

endpackage

// ----- rtl/pcpa_ctrl.sv -----
// Controller state machine of the page allocator.
// Depends on pcpa_pkg for states, datapath operations and status structs.
module pcpa_ctrl
    import pcpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FN_ALLOC: begin
                        if (i_stat.cpu_nonempty)      n_state = S_CPU_RD;
                        else if (i_stat.glb_nonempty) n_state = S_GLB_RD;
                        else                          n_state = S_ST_CPU;
                    end
                    FN_INIT: n_state = S_INIT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_CPU_RD: n_state = S_IDLE;
            S_GLB_RD: n_state = S_IDLE;
            S_INIT: begin
                if (!i_stat.init_more) n_state = S_IDLE;
            end
            S_ST_CPU: begin
                if (i_stat.st_end) begin
                    n_state = i_stat.glb_nonempty ? S_GLB_RD : S_IDLE;
                end else if (!i_stat.st_is_me) begin
                    n_state = S_ST_WALK;
                end
            end
            S_ST_WALK: n_state = i_stat.walk_more ? S_ST_WR : S_ST_CPU;
            S_ST_WR:   n_state = S_ST_WALK;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) o_cmd.op = OP_LATCH;
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FN_ALLOC: begin
                        if (i_stat.cpu_nonempty)      o_cmd.op = OP_CPU_RD;
                        else if (i_stat.glb_nonempty) o_cmd.op = OP_GLB_RD;
                        else                          o_cmd.op = OP_ST_INIT;
                    end
                    FN_FREE: o_cmd.op = i_stat.free_ok ? OP_FREE : OP_RESP_BAD;
                    FN_INIT: o_cmd.op = OP_INIT_SET;
                    default: o_cmd.op = OP_RESP_OK;
                endcase
            end
            S_CPU_RD: o_cmd.op = OP_POP_CPU;
            S_GLB_RD: o_cmd.op = OP_POP_GLB;
            S_INIT:   o_cmd.op = i_stat.init_more ? OP_INIT_PUSH : OP_RESP_OK;
            S_ST_CPU: begin
                if (i_stat.st_end) begin
                    o_cmd.op = i_stat.glb_nonempty ? OP_GLB_RD : OP_RESP_OOM;
                end else begin
                    o_cmd.op = i_stat.st_is_me ? OP_ST_NEXT : OP_ST_LOAD;
                end
            end
            S_ST_WALK: o_cmd.op = i_stat.walk_more ? OP_ST_RD : OP_ST_END;
            S_ST_WR:   o_cmd.op = OP_ST_PUSH;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/pcpa_dp.sv -----
// Datapath of the page allocator: link memory, list heads, address checks
// and the result register. Depends on pcpa_pkg for codes and structs.
module pcpa_dp
    import pcpa_pkg::*;
#(
    parameter int unsigned NUM_PAGES = DEF_NUM_PAGES,
    parameter int unsigned NUM_CPUS  = DEF_NUM_CPUS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [ADDR_W-1:0]   i_cfg_data,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [CPU_W-1:0]    i_cpu,
    input  logic [ADDR_W-1:0]   i_page_address,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_alloc_address,
    output logic [STATUS_W-1:0] o_status
);

    localparam int unsigned AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int unsigned LW  = $clog2(NUM_PAGES + 1);
    localparam int unsigned CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int unsigned CCW = $clog2(NUM_CPUS + 1);
    localparam logic [LW-1:0]  NULL_L = LW'(NUM_PAGES);
    localparam logic [CCW-1:0] NCPU_C = CCW'(NUM_CPUS);
    localparam logic [ADDR_W:0] PG_MASK = {{(ADDR_W+1-PAGE_SH){1'b1}}, {PAGE_SH{1'b0}}};

    logic [ADDR_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_top;
    logic [FUNC_W-1:0]   r_func;
    logic [CW-1:0]       r_cpu;
    logic [ADDR_W-1:0]   r_pa;
    logic [CW-1:0]       r_hsel;
    logic [CCW-1:0]      r_c;
    logic [LW-1:0]       r_p;
    logic [LW-1:0]       r_moves;
    logic [LW-1:0]       r_idx;
    logic [ADDR_W+1:0]   r_pg;
    logic [LW-1:0]       r_ghead;
    logic [LW-1:0]       r_head [NUM_CPUS];
    logic [LW-1:0]       r_rdata;
    logic [LW-1:0]       r_mem [NUM_PAGES];
    logic                r_done;
    logic [ADDR_W-1:0]   r_addr;
    logic [STATUS_W-1:0] r_status;

    logic [CW-1:0]       cpu_m;
    logic [ADDR_W:0]     start_pg;
    logic [ADDR_W:0]     diff;
    logic [ADDR_W-PAGE_SH:0] pidx;
    logic [LW-1:0]       head_cur;
    logic [ADDR_W:0]     pop_addr;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;
    logic [LW-1:0]       mem_wdata;

    // Processor number folded into range through a small table.
    always_comb begin
        cpu_m = '0;
        for (int k = 0; k < 8; k++) begin
            if (i_cpu == CPU_W'(k)) cpu_m = CW'(k % NUM_CPUS);
        end
    end

    // Page arithmetic from the current base.
    assign start_pg = ({1'b0, r_base} + (ADDR_W+1)'(4095)) & PG_MASK;
    assign diff     = {1'b0, r_pa} - start_pg;
    assign pidx     = diff[ADDR_W:PAGE_SH];
    assign head_cur = r_head[r_hsel];
    assign pop_addr = start_pg + ((ADDR_W+1)'(r_idx) << PAGE_SH);

    // Status toward the controller.
    always_comb begin
        o_stat.func         = r_func;
        o_stat.cpu_nonempty = (head_cur < NULL_L);
        o_stat.glb_nonempty = (r_ghead < NULL_L);
        o_stat.free_ok      = (r_pa[PAGE_SH-1:0] == '0) && (r_pa >= r_base) &&
                              (r_pa < r_top) && ({1'b0, r_pa} >= start_pg) &&
                              (pidx < (ADDR_W-PAGE_SH+1)'(NUM_PAGES));
        o_stat.init_more    = ((r_pg + (ADDR_W+2)'(4096)) <= {2'b00, r_top}) &&
                              (r_p < NULL_L);
        o_stat.st_end       = (r_c == NCPU_C);
        o_stat.st_is_me     = (r_c == CCW'(r_cpu));
        o_stat.walk_more    = (r_p < NULL_L) && (r_moves < NULL_L);
    end

    // Link memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_p[AW-1:0];
        mem_wdata = r_ghead;
        case (i_cmd.op)
            OP_CPU_RD: begin
                mem_re   = 1'b1;
                mem_addr = head_cur[AW-1:0];
            end
            OP_GLB_RD: begin
                mem_re   = 1'b1;
                mem_addr = r_ghead[AW-1:0];
            end
            OP_ST_RD: mem_re = 1'b1;
            OP_FREE: begin
                mem_we    = 1'b1;
                mem_addr  = pidx[AW-1:0];
                mem_wdata = head_cur;
            end
            OP_INIT_PUSH: mem_we = 1'b1;
            OP_ST_PUSH:   mem_we = 1'b1;
            default: ;
        endcase
    end

    // Link memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_addr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_top  <= TOP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BASE) r_base <= i_cfg_data;
            if (i_cfg_idx == CFG_TOP)  r_top  <= i_cfg_data;
        end
    end

    // List heads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghead <= NULL_L;
            for (int k = 0; k < NUM_CPUS; k++) r_head[k] <= NULL_L;
        end else begin
            case (i_cmd.op)
                OP_POP_CPU:   r_head[r_hsel] <= r_rdata;
                OP_POP_GLB:   r_ghead <= r_rdata;
                OP_FREE:      r_head[r_hsel] <= LW'(pidx);
                OP_INIT_PUSH: r_ghead <= r_p;
                OP_ST_PUSH:   r_ghead <= r_p;
                OP_ST_END:    r_head[r_hsel] <= NULL_L;
                default: ;
            endcase
        end
    end

    // Operation registers and walk counters.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_func <= i_func;
                r_cpu  <= cpu_m;
                r_hsel <= cpu_m;
                r_pa   <= i_page_address;
            end
            OP_CPU_RD: r_idx <= head_cur;
            OP_GLB_RD: r_idx <= r_ghead;
            OP_INIT_SET: begin
                r_pg <= {1'b0, start_pg};
                r_p  <= '0;
            end
            OP_INIT_PUSH: begin
                r_pg <= r_pg + (ADDR_W+2)'(4096);
                r_p  <= r_p + LW'(1);
            end
            OP_ST_INIT: begin
                r_c    <= '0;
                r_hsel <= '0;
            end
            OP_ST_NEXT, OP_ST_END: begin
                r_c    <= r_c + CCW'(1);
                r_hsel <= CW'(r_c + CCW'(1));
            end
            OP_ST_LOAD: begin
                r_p     <= head_cur;
                r_moves <= '0;
            end
            OP_ST_PUSH: begin
                r_p     <= r_rdata;
                r_moves <= r_moves + LW'(1);
            end
            default: ;
        endcase
    end

    // Result register: one strobe per finished operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.op == OP_POP_CPU) || (i_cmd.op == OP_POP_GLB) ||
                      (i_cmd.op == OP_FREE) || (i_cmd.op == OP_RESP_OK) ||
                      (i_cmd.op == OP_RESP_OOM) || (i_cmd.op == OP_RESP_BAD);
        end
        case (i_cmd.op)
            OP_POP_CPU, OP_POP_GLB: begin
                r_addr   <= pop_addr[ADDR_W-1:0];
                r_status <= ST_OK;
            end
            OP_RESP_OOM: begin
                r_addr   <= '0;
                r_status <= ST_OOM;
            end
            OP_RESP_BAD: begin
                r_addr   <= '0;
                r_status <= ST_BAD_FREE;
            end
            OP_FREE, OP_RESP_OK: begin
                r_addr   <= '0;
                r_status <= ST_OK;
            end
            default: ;
        endcase
    end

    assign o_done          = r_done;
    assign o_alloc_address = r_addr;
    assign o_status        = r_status;

endmodule

// ----- rtl/per_cpu_page_free_list_allocator_top.sv -----
// Top level of the per-CPU page free list allocator.
// Instantiates pcpa_ctrl and pcpa_dp; depends on pcpa_pkg.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+------------------------------------
//   command  | start / busy         | i_func, i_cpu, i_page_address
//   result   | o_done (strobe)      | o_alloc_address, o_status
//   config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A command is taken when start is high and busy is low. It is latched and
// dispatched; free and unused codes answer from dispatch, a list allocation
// reads the link memory and then pops the head, init pushes each page onto
// the global list, and a steal first moves the other processors' pages to
// it. A new command may be taken in the cycle of the strobe.
// Reset is synchronous; the link memory is not cleared. Results cannot stall.
module per_cpu_page_free_list_allocator_top
    import pcpa_pkg::*;
#(
    parameter int unsigned NUM_PAGES = DEF_NUM_PAGES,
    parameter int unsigned NUM_CPUS  = DEF_NUM_CPUS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [ADDR_W-1:0]   i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [CPU_W-1:0]    i_cpu,
    input  logic [ADDR_W-1:0]   i_page_address,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_alloc_address,
    output logic [STATUS_W-1:0] o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    pcpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Storage and arithmetic.
    pcpa_dp #(
        .NUM_PAGES (NUM_PAGES),
        .NUM_CPUS  (NUM_CPUS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_cpu           (i_cpu),
        .i_page_address  (i_page_address),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_alloc_address (o_alloc_address),
        .o_status        (o_status)
    );

endmodule

// ----- rtl/pcpa_checker.sv -----
// Port-level checker for the page allocator top level, with its bind.
// Depends on pcpa_pkg for widths and status codes.
module pcpa_checker
    import pcpa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [ADDR_W-1:0]   o_alloc_address,
    input logic [STATUS_W-1:0] o_status
);

    // A taken command keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after transfer");

    // A result is shown only once the block has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");

    // Results never come in back-to-back cycles.
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("two results in a row");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_OOM ||
                    o_status == ST_BAD_FREE)) else $error("bad status code");

    // A failed operation returns address zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_alloc_address == '0))
        else $error("nonzero address on failure");

endmodule

bind per_cpu_page_free_list_allocator_top pcpa_checker u_pcpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_alloc_address (o_alloc_address),
    .o_status        (o_status)
);
